@@ rtl/core/wtsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Wrapped texture span drawer package
// Shared codes, widths and the queue entry type.
// ----------------------------------------------------------------------------
package wtsd_pkg;

  localparam int unsigned MaxDimDefault   = 512;
  localparam int unsigned TexDepthDefault = 262144;
  localparam int unsigned FracBitsDefault = 16;

  localparam logic [2:0] OP_LOAD_TEX   = 3'd0;
  localparam logic [2:0] OP_LOAD_SHADE = 3'd1;
  localparam logic [2:0] OP_LOAD_BLEND = 3'd2;
  localparam logic [2:0] OP_START      = 3'd3;
  localparam logic [2:0] OP_DRAW       = 3'd4;

  localparam logic [2:0] MODE_OPAQUE     = 3'd0;
  localparam logic [2:0] MODE_SPLAT      = 3'd1;
  localparam logic [2:0] MODE_TRANS      = 3'd2;
  localparam logic [2:0] MODE_TRANS_SPLAT = 3'd3;
  localparam logic [2:0] MODE_WATER      = 3'd4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_TRANS  = 2'd3;

  // Classified item handed from front to back.
  typedef enum logic [2:0] {
    KIND_TEX   = 3'b001,
    KIND_SHADE = 3'b010,
    KIND_BLEND = 3'b100
  } kind_e;

  typedef struct packed {
    logic        is_draw;
    kind_e       kind;
    logic [17:0] addr;
    logic [7:0]  data;
    logic [7:0]  dest;
    logic [7:0]  back;
    logic [31:0] xpos;
    logic [31:0] ypos;
  } item_t;

endpackage

@@ rtl/core/wtsd_front.sv @@
// ----------------------------------------------------------------------------
// Wrapped texture span drawer front end
// Accepts beats, keeps the span positions and queues classified items.
// ----------------------------------------------------------------------------
module wtsd_front import wtsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [17:0] load_addr_i,
  input  logic [7:0]  load_data_i,
  input  logic [31:0] start_x_pos_i,
  input  logic [31:0] start_y_pos_i,
  input  logic [31:0] x_step_in_i,
  input  logic [31:0] y_step_in_i,
  input  logic [7:0]  dest_pixel_i,
  input  logic [7:0]  back_pixel_i,
  output logic        q_valid_o,
  output item_t       q_item_o,
  input  logic        q_pop_i
);

  logic [31:0] xpos_q, ypos_q, xinc_q, yinc_q;
  item_t       ent_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        acc, push;
  item_t       it;

  assign stall_o = (cnt_q == 2'd2);
  assign acc     = valid_i && !stall_o;
  assign push    = acc && (opcode_i == OP_LOAD_TEX || opcode_i == OP_LOAD_SHADE ||
                           opcode_i == OP_LOAD_BLEND || opcode_i == OP_DRAW);

  always_comb begin
    it = '0;
    it.is_draw = (opcode_i == OP_DRAW);
    it.kind    = (opcode_i == OP_LOAD_SHADE) ? KIND_SHADE :
                 (opcode_i == OP_LOAD_BLEND) ? KIND_BLEND : KIND_TEX;
    it.addr = load_addr_i;
    it.data = load_data_i;
    it.dest = dest_pixel_i;
    it.back = back_pixel_i;
    it.xpos = xpos_q;
    it.ypos = ypos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xpos_q <= '0; ypos_q <= '0; xinc_q <= '0; yinc_q <= '0;
    end else if (acc && opcode_i == OP_START) begin
      xpos_q <= start_x_pos_i; ypos_q <= start_y_pos_i;
      xinc_q <= x_step_in_i;   yinc_q <= y_step_in_i;
    end else if (acc && opcode_i == OP_DRAW) begin
      xpos_q <= xpos_q + xinc_q;
      ypos_q <= ypos_q + yinc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = ent_q[rp_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push || q_pop_i) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

@@ rtl/core/wtsd_back.sv @@
// ----------------------------------------------------------------------------
// Wrapped texture span drawer back end
// Wraps coordinates, fetches the texel and runs the shade and blend lookups.
// ----------------------------------------------------------------------------
module wtsd_back import wtsd_pkg::*; #(
  parameter int unsigned MaxDim   = MaxDimDefault,
  parameter int unsigned TexDepth = TexDepthDefault,
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  input  logic [9:0] flat_width_i,
  input  logic [9:0] flat_height_i,
  input  logic [2:0] draw_mode_i,
  input  logic [7:0] transparent_index_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] pixel_value_o,
  output logic       write_pixel_o
);

  localparam int DW = $clog2(MaxDim + 1);
  localparam int AW = $clog2(TexDepth);
  localparam int IW = 32 - FracBits;
  localparam int PW = AW + DW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV   = 9'b000000010,
    ST_ADDR  = 9'b000000100,
    ST_TEX   = 9'b000001000,
    ST_LK1   = 9'b000010000,
    ST_LK1W  = 9'b000100000,
    ST_LK2   = 9'b001000000,
    ST_LK2W  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e      st_q;
  item_t       it_q;
  logic [7:0]  tex_mem [TexDepth];
  logic [7:0]  shade_mem [256];
  logic [7:0]  blend_mem [65536];
  logic [7:0]  tex_rd_q, shade_rd_q, blend_rd_q;
  logic [AW-1:0] tex_ra;
  logic [7:0]  shade_ra;
  logic [15:0] blend_ra;
  logic        tex_re, shade_re, blend_re;

  logic [DW-1:0] w_q, h_q;
  logic [DW-1:0] rx_q, ry_q;   // running remainder of the integer magnitude
  logic [4:0]    bit_q;
  logic [IW-1:0] qx_q, qy_q;   // shifting integer parts
  logic          xneg_q, yneg_q;
  logic [PW-1:0] prod_q;
  logic [7:0]    t_q;
  logic [7:0]    pix_q;
  logic          wr_q, obuf_q;

  function automatic logic [DW-1:0] eff(input logic [9:0] s);
    logic [31:0] m;
    m = 32'(MaxDim);
    if (s == 10'd0) return DW'(1);
    if ({22'd0, s} > m) return DW'(MaxDim);
    return DW'(s);
  endfunction

  // Restoring division step on magnitude; remainder kept below size.
  function automatic logic [DW-1:0] rstep(input logic [DW-1:0] r, input logic b,
                                          input logic [DW-1:0] d);
    logic [DW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[DW-1:0];
  endfunction

  logic [DW-1:0] remx, remy;
  assign remx = rx_q;
  assign remy = ry_q;

  logic [DW-1:0] cx, cy;
  // floor mod of negative n: magnitude m = ~n; result = d-1 - (m mod d)
  assign cx = xneg_q ? (w_q - DW'(1) - remx) : remx;
  assign cy = yneg_q ? (h_q - DW'(1) - remy) : remy;

  assign q_pop_o = (st_q == ST_IDLE) && q_valid_i;

  always_comb begin
    tex_re = (st_q == ST_TEX);
    tex_ra = AW'(prod_q + PW'(cx));
    shade_re = 1'b0; blend_re = 1'b0;
    shade_ra = t_q; blend_ra = '0;
    if (st_q == ST_LK1) begin
      if (draw_mode_i == MODE_WATER) begin
        blend_re = 1'b1; blend_ra = {tex_rd_q, it_q.back};
      end else begin
        shade_re = 1'b1; shade_ra = tex_rd_q;
      end
    end else if (st_q == ST_LK2) begin
      if (draw_mode_i == MODE_WATER) begin
        shade_re = 1'b1; shade_ra = blend_rd_q;
      end else begin
        blend_re = 1'b1; blend_ra = {shade_rd_q, it_q.dest};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DIV && !it_q.is_draw && it_q.kind == KIND_TEX)
      tex_mem[AW'(it_q.addr)] <= it_q.data;
    if (tex_re) tex_rd_q <= tex_mem[tex_ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DIV && !it_q.is_draw && it_q.kind == KIND_SHADE)
      shade_mem[it_q.addr[7:0]] <= it_q.data;
    if (shade_re) shade_rd_q <= shade_mem[shade_ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DIV && !it_q.is_draw && it_q.kind == KIND_BLEND)
      blend_mem[it_q.addr[15:0]] <= it_q.data;
    if (blend_re) blend_rd_q <= blend_mem[blend_ra];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q   <= q_item_i;
      w_q    <= eff(flat_width_i);
      h_q    <= eff(flat_height_i);
      xneg_q <= q_item_i.xpos[31];
      yneg_q <= q_item_i.ypos[31];
      qx_q   <= q_item_i.xpos[31] ? ~q_item_i.xpos[31 -: IW] : q_item_i.xpos[31 -: IW];
      qy_q   <= q_item_i.ypos[31] ? ~q_item_i.ypos[31 -: IW] : q_item_i.ypos[31 -: IW];
      rx_q   <= '0;
      ry_q   <= '0;
    end else if (st_q == ST_DIV) begin
      rx_q <= rstep(remx, qx_q[IW-1], w_q);
      ry_q <= rstep(remy, qy_q[IW-1], h_q);
      qx_q <= {qx_q[IW-2:0], 1'b0};
      qy_q <= {qy_q[IW-2:0], 1'b0};
    end
    if (st_q == ST_ADDR) prod_q <= PW'(cy) * PW'(w_q);
    if (st_q == ST_LK1) t_q <= tex_rd_q;
  end

  logic splat_skip;
  assign splat_skip = (t_q == transparent_index_i) &&
                      (draw_mode_i == MODE_SPLAT || draw_mode_i == MODE_TRANS_SPLAT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; bit_q <= '0; obuf_q <= 1'b0;
      pix_q <= '0; wr_q <= 1'b0;
    end else begin
      if (st_q == ST_OUT && (!obuf_q || !stall_i)) obuf_q <= 1'b1;
      else if (obuf_q && !stall_i) obuf_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (q_pop_o) begin
          st_q <= ST_DIV; bit_q <= 5'(IW - 1);
        end
        ST_DIV: begin
          if (!it_q.is_draw) st_q <= ST_IDLE;
          else if (bit_q == 5'd0) st_q <= ST_ADDR;
          else bit_q <= bit_q - 5'd1;
        end
        ST_ADDR: st_q <= ST_TEX;
        ST_TEX:  st_q <= ST_LK1;
        ST_LK1:  st_q <= ST_LK1W;
        ST_LK1W: st_q <= ST_LK2;
        ST_LK2:  st_q <= ST_LK2W;
        ST_LK2W: st_q <= ST_OUT;
        ST_OUT: if (!obuf_q || !stall_i) begin
          st_q   <= ST_IDLE;
          unique case (draw_mode_i) inside
            MODE_OPAQUE, MODE_SPLAT: begin
              pix_q <= splat_skip ? 8'd0 : shade_rd_q; wr_q <= !splat_skip;
            end
            MODE_TRANS, MODE_TRANS_SPLAT: begin
              pix_q <= splat_skip ? 8'd0 : blend_rd_q; wr_q <= !splat_skip;
            end
            MODE_WATER: begin pix_q <= shade_rd_q; wr_q <= 1'b1; end
            default: begin pix_q <= 8'd0; wr_q <= 1'b0; end
          endcase
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign valid_o       = obuf_q;
  assign pixel_value_o = pix_q;
  assign write_pixel_o = wr_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> st_q == ST_DIV) else $error("pop did not start work");
  a_cx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_ADDR |-> cx < w_q && cy < h_q) else $error("wrap out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    obuf_q && stall_i |=> obuf_q && $stable(pix_q)) else $error("result lost");

endmodule

@@ rtl/core/wrapped_texture_span_drawer.sv @@
// ----------------------------------------------------------------------------
// Wrapped texture span drawer
// Affine 8-bit texture span rasterizer with non-power-of-two wrap.
// ----------------------------------------------------------------------------
// A draw beat accepted into an idle back end passes the floor-modulo divider,
// which steps bit-serially through the IW = 32 - FracBits integer bits, then
// the address, texel, lookup and output states; loads write their table in
// the divide state. The back end takes one item at a time; span starts stay
// in the front. Reset clears positions, steps, registers and the queue; the
// three table memories hold nothing defined until written.
module wrapped_texture_span_drawer import wtsd_pkg::*; #(
  parameter int unsigned MaxDim   = MaxDimDefault,
  parameter int unsigned TexDepth = TexDepthDefault,
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [17:0] load_addr_i,
  input  logic [7:0]  load_data_i,
  input  logic [31:0] start_x_pos_i,
  input  logic [31:0] start_y_pos_i,
  input  logic [31:0] x_step_in_i,
  input  logic [31:0] y_step_in_i,
  input  logic [7:0]  dest_pixel_i,
  input  logic [7:0]  back_pixel_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  pixel_value_o,
  output logic        write_pixel_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  // Configuration registers; the user must write them only while the block is idle; not enforced.
  logic [9:0] width_q, height_q;
  logic [2:0] mode_q;
  logic [7:0] trans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 10'd64; height_q <= 10'd64; mode_q <= MODE_OPAQUE; trans_q <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[2:0];
        REG_TRANS:  trans_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The front classifies beats and advances positions at acceptance time, so
  // each queued draw beat carries its own snapshot of the x/y positions.
  logic  q_valid, q_pop;
  item_t q_item;

  wtsd_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .opcode_i, .load_addr_i, .load_data_i,
    .start_x_pos_i, .start_y_pos_i, .x_step_in_i, .y_step_in_i,
    .dest_pixel_i, .back_pixel_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  // The back performs table writes and the per-pixel pipeline of lookups.
  wtsd_back #(.MaxDim(MaxDim), .TexDepth(TexDepth), .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .flat_width_i(width_q), .flat_height_i(height_q),
    .draw_mode_i(mode_q), .transparent_index_i(trans_q),
    .valid_o, .stall_i, .pixel_value_o, .write_pixel_o
  );

  a_cfg_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == REG_MODE |=> mode_q == $past(cfg_data_i[2:0]))
    else $error("mode write lost");
  a_valid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o) else $error("result dropped under stall");
  a_pop_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop without item");

endmodule

@@ tb/sv/tb_wrapped_texture_span_drawer.sv @@
// ----------------------------------------------------------------------------
// Wrapped texture span drawer testbench
// Loads the texture, shade and blend stores, then drives start-span and draw
// beats under several register settings and idle patterns. A scoreboard class
// predicts every pixel and checks each output beat against the oldest one.
// ----------------------------------------------------------------------------
module tb_wrapped_texture_span_drawer import wtsd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DimMax    = 512;
  localparam int unsigned TexSize   = 262144;
  localparam int unsigned TexFill   = 512;
  localparam int unsigned FracWidth = 16;
  localparam int unsigned CycleLimit = 2000000;

  // Expected output of one draw beat.
  typedef struct {
    logic [7:0] pixel;
    logic       wr;
  } pixel_t;

  // The scoreboard keeps its own copy of the stores, positions and registers.
  class pixel_scoreboard;
    logic [7:0]  tex_mem [TexSize];
    logic [7:0]  shade_mem [256];
    logic [7:0]  blend_mem [65536];
    logic [31:0] xp, yp, xs, ys;
    logic [9:0]  width_reg, height_reg;
    logic [2:0]  mode_reg;
    logic [7:0]  trans_reg;
    pixel_t      pending[$];
    int          errors;

    function new();
      xp = 0; yp = 0; xs = 0; ys = 0;
      width_reg = 64; height_reg = 64; mode_reg = MODE_OPAQUE; trans_reg = 255;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        REG_WIDTH:  width_reg  = val;
        REG_HEIGHT: height_reg = val;
        REG_MODE:   mode_reg   = val[2:0];
        default:    trans_reg  = val[7:0];
      endcase
    endfunction

    function int unsigned clamp_size(logic [9:0] s);
      if (s == 0) return 1;
      if (s > DimMax) return DimMax;
      return s;
    endfunction

    // Floor of the 16.16 position, then floor modulo by the size.
    function int unsigned wrap(logic [31:0] pos, int unsigned size);
      longint ip;
      longint m;
      ip = longint'($signed(pos)) >>> FracWidth;
      m = ip % longint'(size);
      if (m < 0) m += size;
      return int'(m);
    endfunction

    function void note_beat(logic [2:0] op, logic [17:0] addr, logic [7:0] data,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] dx,
                            logic [31:0] dy, logic [7:0] dst, logic [7:0] bck);
      int unsigned w, h, cx, cy;
      longint unsigned ta;
      logic [7:0] t, sh;
      pixel_t r;
      case (op)
        OP_LOAD_TEX:   tex_mem[addr % TexSize] = data;
        OP_LOAD_SHADE: shade_mem[addr[7:0]] = data;
        OP_LOAD_BLEND: blend_mem[addr[15:0]] = data;
        OP_START: begin
          xp = sx; yp = sy; xs = dx; ys = dy;
        end
        OP_DRAW: begin
          w = clamp_size(width_reg);
          h = clamp_size(height_reg);
          cx = wrap(xp, w);
          cy = wrap(yp, h);
          ta = (longint'(cy) * w + cx) % TexSize;
          t = tex_mem[ta];
          sh = shade_mem[t];
          r.pixel = 0;
          r.wr = 0;
          case (mode_reg)
            MODE_OPAQUE: begin
              r.pixel = sh; r.wr = 1;
            end
            MODE_SPLAT: if (t != trans_reg) begin
              r.pixel = sh; r.wr = 1;
            end
            MODE_TRANS: begin
              r.pixel = blend_mem[{sh, dst}]; r.wr = 1;
            end
            MODE_TRANS_SPLAT: if (t != trans_reg) begin
              r.pixel = blend_mem[{sh, dst}]; r.wr = 1;
            end
            MODE_WATER: begin
              r.pixel = shade_mem[blend_mem[{t, bck}]]; r.wr = 1;
            end
            default: ;
          endcase
          xp = xp + xs;
          yp = yp + ys;
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [7:0] pix, logic wr);
      pixel_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output beat pixel %0d write %0d", $time, pix, wr);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pix !== e.pixel) begin
        $display("%0t: pixel_value expected %0d actual %0d", $time, e.pixel, pix);
        errors++;
      end
      if (wr !== e.wr) begin
        $display("%0t: write_pixel expected %0d actual %0d", $time, e.wr, wr);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [2:0]  opcode_i = '0;
  logic [17:0] load_addr_i = '0;
  logic [7:0]  load_data_i = '0;
  logic [31:0] start_x_pos_i = '0;
  logic [31:0] start_y_pos_i = '0;
  logic [31:0] x_step_in_i = '0;
  logic [31:0] y_step_in_i = '0;
  logic [7:0]  dest_pixel_i = '0;
  logic [7:0]  back_pixel_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [7:0]  pixel_value_o;
  logic        write_pixel_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i = '0;

  // Idle percentages for each side, and the long receiver hold-off request.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  pixel_scoreboard board;

  wrapped_texture_span_drawer DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: sample at the rising edge, then pick the next stall at the
  // falling edge. A hold-off request keeps stall high until its count runs out.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) board.check_pixel(pixel_value_o, write_pixel_o);
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog for a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("wrapped_texture_span_drawer regression: fail");
      $finish;
    end
  end

  // Offer one beat and wait until it is accepted. Valid stays high on return;
  // the next beat, an idle gap, a drain or a register write replaces it at
  // that same falling edge.
  task automatic send_beat(logic [2:0] op, logic [17:0] addr, logic [7:0] data,
                           logic [31:0] sx, logic [31:0] sy, logic [31:0] dx,
                           logic [31:0] dy, logic [7:0] dst, logic [7:0] bck);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    opcode_i <= op;
    load_addr_i <= addr;
    load_data_i <= data;
    start_x_pos_i <= sx;
    start_y_pos_i <= sy;
    x_step_in_i <= dx;
    y_step_in_i <= dy;
    dest_pixel_i <= dst;
    back_pixel_i <= bck;
    do @(posedge clk_i); while (stall_o);
    board.note_beat(op, addr, data, sx, sy, dx, dy, dst, bck);
    @(negedge clk_i);
  endtask

  task automatic load_beat(logic [2:0] op, logic [17:0] addr, logic [7:0] data);
    send_beat(op, addr, data, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
  endtask

  task automatic start_beat(logic [31:0] sx, logic [31:0] sy, logic [31:0] dx,
                            logic [31:0] dy);
    send_beat(OP_START, $urandom, $urandom, sx, sy, dx, dy, $urandom, $urandom);
  endtask

  task automatic draw_beat();
    send_beat(OP_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  // Wait until every expected pixel has arrived, then let any load beat still
  // in the queue or the back end finish before a register is touched.
  task automatic drain();
    valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    valid_i <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Texel and shade values stay at 0 or 1, so only the first two blend rows
  // are ever selected by a texel or a shade entry. Fill those rows, the whole
  // shade table and the texels below the largest texture area that the
  // settings allow, so no draw ever reads an unwritten entry.
  task automatic fill_stores();
    for (int i = 0; i < 256; i++) load_beat(OP_LOAD_SHADE, 18'(i), 8'($urandom_range(1)));
    for (int i = 0; i < 512; i++) begin
      load_beat(OP_LOAD_BLEND, {2'($urandom), 16'(i)}, $urandom);
    end
    for (int i = 0; i < TexFill; i++) load_beat(OP_LOAD_TEX, 18'(i), 8'($urandom_range(1)));
  endtask

  // Random 16.16 step: mostly small, sometimes anything.
  function automatic logic [31:0] rand_step();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(2 ** 21)) - (2 ** 20));
  endfunction

  // One random stretch: sparse table reloads, spans of draws, rare noise.
  task automatic random_stretch(int unsigned beats);
    int unsigned k;
    int unsigned n;
    logic [2:0] op;
    k = 0;
    while (k < beats) begin
      n = $urandom_range(99);
      if (n < 5) begin
        op = 3'($urandom_range(2));
        load_beat(op, $urandom,
                  (op == OP_LOAD_BLEND) ? 8'($urandom) : 8'($urandom_range(1)));
      end else if (n < 7) begin
        op = 3'($urandom_range(7, 5));
        load_beat(op, $urandom, $urandom);
        continue;
      end else begin
        start_beat($urandom, $urandom, rand_step(), rand_step());
        repeat ($urandom_range(12, 1)) begin
          draw_beat();
          k++;
        end
      end
      k++;
    end
  endtask

  // Sizes keep the wrapped texture area within the filled texels.
  task automatic random_settings();
    int unsigned n;
    int unsigned w;
    int unsigned h;
    n = $urandom_range(9);
    if (n == 0) w = 0;
    else if (n == 1) w = $urandom_range(1023, 512);
    else w = $urandom_range(40, 1);
    h = TexFill / board.clamp_size(10'(w));
    n = $urandom_range(9);
    if (n == 0) h = 0;
    else if (n == 1 && h == DimMax) h = $urandom_range(1023, 512);
    else h = $urandom_range(h, 1);
    write_reg(REG_WIDTH, 10'(w));
    write_reg(REG_HEIGHT, 10'(h));
    write_reg(REG_MODE, ($urandom_range(9) == 0) ? 10'($urandom_range(7, 5)) :
              10'($urandom_range(4)));
    write_reg(REG_TRANS, ($urandom_range(3) == 0) ? 10'($urandom_range(255)) :
              10'($urandom_range(1)));
  endtask

  initial begin
    board = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    fill_stores();
    drain();

    // Directed part: every mode, both wrap extremes, zero and oversize sizes,
    // negative and overflowing positions, the transparent texel, bad codes.
    write_reg(REG_WIDTH, 10'd0);
    write_reg(REG_HEIGHT, 10'h3FF);
    start_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    draw_beat();
    draw_beat();
    drain();
    write_reg(REG_WIDTH, 10'd3);
    write_reg(REG_HEIGHT, 10'd512);
    write_reg(REG_TRANS, 10'd0);
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_MODE, 10'(m));
      load_beat(OP_LOAD_TEX, 18'd0, (m % 2) ? 8'd0 : 8'd1);
      start_beat(32'hFFFD_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
      draw_beat();
      draw_beat();
      load_beat(3'd7, 18'h3FFFF, 8'hFF);
      drain();
    end
    write_reg(REG_TRANS, 10'd255);

    // Random phases: receiver idles more, then sender, then neither.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 26 : 0;
      for (int s = 0; s < 6; s++) begin
        random_settings();
        if (ph == 2 && s == 0) begin
          hold_cycles = 400;
          random_stretch(40);
        end else begin
          random_stretch(24);
        end
        // Sender pauses until every expected pixel has come.
        drain();
      end
    end

    recv_idle_pct = 0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("wrapped_texture_span_drawer regression: pass");
    end else begin
      $display("wrapped_texture_span_drawer regression: fail");
    end
    $finish;
  end
endmodule
